FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the back stage of the endpoint-zero control RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ucep_pkg.sv
// Types, constants and helper functions of the endpoint-zero control block.
`default_nettype none

package ucep_pkg;

	// Payload widths
	localparam int RX_COUNT_W    = 10;
	localparam int SETUP_W       = 64;
	localparam int FLAGS_W       = 7;
	localparam int FADDR_W       = 7;
	localparam int SRC_W         = 4;
	localparam int OFFSET_W      = 10;
	localparam int TXLEN_W       = 7;
	localparam int PHASE_W       = 3;
	localparam int CFGVAL_W      = 8;
	localparam int DEVLEN_W      = 8;
	localparam int XFER_W        = 10;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 10;

	// Default packet size of endpoint zero
	localparam int MAX_PACKET_DEF = 64;

	// Configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEV_LEN   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_CFG_TOTAL = 1'b1;
	localparam logic [DEVLEN_W-1:0]  DEV_LEN_RESET     = 8'd18;
	localparam logic [XFER_W-1:0]    CFG_TOTAL_RESET   = 10'd67;

	// Action flag bit positions
	localparam int FLG_CLR_SETEND  = 0;
	localparam int FLG_CLR_STALLED = 1;
	localparam int FLG_RX_ACK      = 2;
	localparam int FLG_TX_READY    = 3;
	localparam int FLG_DATA_END    = 4;
	localparam int FLG_STALL       = 5;
	localparam int FLG_FLUSH       = 6;

	// Request words (bmRequestType:bRequest)
	localparam logic [15:0] REQ_GET_DESCRIPTOR = 16'h8006;
	localparam logic [15:0] REQ_CLEAR_FEATURE  = 16'h0001;
	localparam logic [15:0] REQ_SET_FEATURE    = 16'h0003;
	localparam logic [15:0] REQ_SET_ADDRESS    = 16'h0005;
	localparam logic [15:0] REQ_SET_CONFIG     = 16'h0009;
	localparam logic [15:0] REQ_CDC_LINE_STATE = 16'h2122;
	localparam int          REQ_DIR_IN_BIT     = 15;

	// Descriptor types in wValue high byte
	localparam logic [7:0] DT_DEVICE = 8'd1;
	localparam logic [7:0] DT_CONFIG = 8'd2;
	localparam logic [7:0] DT_STRING = 8'd3;
	localparam logic [7:0] NUM_STRINGS = 8'd6;

	// Descriptor source codes
	localparam logic [SRC_W-1:0] SRC_NONE    = 4'd0;
	localparam logic [SRC_W-1:0] SRC_DEVICE  = 4'd1;
	localparam logic [SRC_W-1:0] SRC_CONFIG  = 4'd2;
	localparam logic [SRC_W-1:0] SRC_STRING0 = 4'd3;

	// Only an 8-byte packet is a setup packet
	localparam logic [RX_COUNT_W-1:0] SETUP_LEN = 10'd8;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [PHASE_W-1:0] {
		PH_RESET  = 3'd0,
		PH_IDLE   = 3'd1,
		PH_TX     = 3'd2,
		PH_STATUS = 3'd3,
		PH_ZERO   = 3'd4,
		PH_RX     = 3'd5
	} phase_t;

	// Request class found by the front
	typedef enum logic [2:0] {
		CMD_STALL,
		CMD_ZERO_OK,
		CMD_SET_ADDR,
		CMD_SET_CFG,
		CMD_READ,
		CMD_WRITE
	} cmd_class_t;

	// Classified event handed from front to back
	typedef struct packed {
		logic              bus_reset;
		logic              setup_end;
		logic              stalled;
		logic              rx_ready;
		logic              oversize;
		logic              setup_ok;
		cmd_class_t        cls;
		logic [7:0]        wval_lo;
		logic [SRC_W-1:0]  desc;
		logic [XFER_W-1:0] total;
	} cmd_t;

	// Byte length of string descriptors: two bytes per character plus header
	function automatic logic [XFER_W-1:0] str_len(input logic [2:0] idx);
		logic [XFER_W-1:0] len;
		unique case (idx)
			3'd0:    len = 10'd4;
			3'd1:    len = 10'd24;
			3'd2:    len = 10'd26;
			3'd3:    len = 10'd18;
			3'd4:    len = 10'd16;
			3'd5:    len = 10'd8;
			default: len = 10'd0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ucep_ifs.sv
// Handshake interfaces: endpoint event in, result out, configuration write.
`default_nettype none

interface ep_event_if
	import ucep_pkg::*;
	();
	logic                  valid;
	logic                  ready;
	logic                  req_type;
	logic                  setup_end;
	logic                  stalled_flag;
	logic                  rx_ready;
	logic [RX_COUNT_W-1:0] rx_count;
	logic [SETUP_W-1:0]    setup_bytes;

	modport source (output valid, req_type, setup_end, stalled_flag, rx_ready, rx_count,
		setup_bytes, input ready);
	modport sink (input valid, req_type, setup_end, stalled_flag, rx_ready, rx_count,
		setup_bytes, output ready);
endinterface

interface ep_result_if
	import ucep_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [FLAGS_W-1:0]  action_flags;
	logic                addr_write;
	logic [FADDR_W-1:0]  func_address;
	logic [SRC_W-1:0]    tx_source;
	logic [OFFSET_W-1:0] tx_offset;
	logic [TXLEN_W-1:0]  tx_length;
	logic [PHASE_W-1:0]  ep_phase;
	logic [CFGVAL_W-1:0] configuration_value;

	modport source (output valid, action_flags, addr_write, func_address, tx_source,
		tx_offset, tx_length, ep_phase, configuration_value, input ready);
	modport sink (input valid, action_flags, addr_write, func_address, tx_source,
		tx_offset, tx_length, ep_phase, configuration_value, output ready);
endinterface

interface cfg_wr_if
	import ucep_pkg::*;
	();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ucep_front.sv
// Front stage: accepts endpoint events and classifies the setup request.
`default_nettype none

module ucep_front
	import ucep_pkg::*;
#(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	ep_event_if.sink                 ev,
	input  wire logic [DEVLEN_W-1:0] dev_len,
	input  wire logic [XFER_W-1:0]   cfg_total,
	output logic                     valid_s1,
	output cmd_t                     cmd_s1,
	input  wire logic                push_ready
);

	logic        accept;
	logic        push;
	cmd_t        cmd_d;
	logic [15:0] req;
	logic [15:0] wvalue;
	logic [15:0] wlength;
	logic [XFER_W-1:0] desc_len;
	logic [SRC_W-1:0]  desc_sel;
	logic        desc_hit;

	assign push     = valid_s1 && push_ready;
	assign ev.ready = !valid_s1 || push_ready;
	assign accept   = ev.valid && ev.ready;

	// Setup packet fields, byte zero in the low bits
	assign req     = {ev.setup_bytes[7:0], ev.setup_bytes[15:8]};
	assign wvalue  = ev.setup_bytes[31:16];
	assign wlength = ev.setup_bytes[63:48];

	// Descriptor lookup for GET_DESCRIPTOR
	always_comb begin
		desc_hit = 1'b1;
		desc_len = '0;
		desc_sel = SRC_NONE;
		if (wvalue[15:8] == DT_DEVICE) begin
			desc_sel = SRC_DEVICE;
			desc_len = XFER_W'(dev_len);
		end else if (wvalue[15:8] == DT_CONFIG) begin
			desc_sel = SRC_CONFIG;
			desc_len = cfg_total;
		end else if (wvalue[15:8] == DT_STRING && wvalue[7:0] < NUM_STRINGS) begin
			desc_sel = SRC_STRING0 + SRC_W'(wvalue[2:0]);
			desc_len = str_len(wvalue[2:0]);
		end else begin
			desc_hit = 1'b0;
		end
	end

	// Request classification
	always_comb begin
		cmd_d.bus_reset = ev.req_type;
		cmd_d.setup_end = ev.setup_end;
		cmd_d.stalled   = ev.stalled_flag;
		cmd_d.rx_ready  = ev.rx_ready;
		cmd_d.oversize  = ev.rx_count > RX_COUNT_W'(MAX_PACKET);
		cmd_d.setup_ok  = ev.rx_count == SETUP_LEN;
		cmd_d.wval_lo   = wvalue[7:0];
		cmd_d.desc      = desc_sel;
		cmd_d.total     = (wlength < 16'(desc_len)) ? wlength[XFER_W-1:0] : desc_len;
		if (wlength == 16'd0) begin
			unique case (req)
				REQ_CLEAR_FEATURE, REQ_SET_FEATURE, REQ_CDC_LINE_STATE:
					cmd_d.cls = CMD_ZERO_OK;
				REQ_SET_ADDRESS: cmd_d.cls = CMD_SET_ADDR;
				REQ_SET_CONFIG:  cmd_d.cls = CMD_SET_CFG;
				default:         cmd_d.cls = CMD_STALL;
			endcase
		end else if (req[REQ_DIR_IN_BIT]) begin
			cmd_d.cls = (req == REQ_GET_DESCRIPTOR && desc_hit) ? CMD_READ : CMD_STALL;
		end else begin
			cmd_d.cls = CMD_WRITE;
		end
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ucep_queue.sv
// Short queue of classified events between front and back.
`default_nettype none

module ucep_queue
	import ucep_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	output logic      push_ready,
	input  wire logic pop,
	output cmd_t      pop_cmd,
	output logic      pop_valid
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entries_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ucep_back.sv
// Back stage: control-transfer state machine and registered result.
`default_nettype none

`include "assert_macros.svh"

module ucep_back
	import ucep_pkg::*;
#(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cmd_t      cmd,
	input  wire logic cmd_valid,
	output logic      pop,
	ep_result_if.source res
);

	// Endpoint state
	phase_t            phase_q;
	logic [7:0]        pend_addr_q;
	logic [7:0]        sel_cfg_q;
	logic [FADDR_W-1:0] func_addr_q;
	logic [XFER_W-1:0] remain_q;
	logic [XFER_W-1:0] pos_q;
	logic [SRC_W-1:0]  desc_q;

	// Next state
	phase_t            phase_n;
	logic [7:0]        pend_addr_n;
	logic [7:0]        sel_cfg_n;
	logic [FADDR_W-1:0] func_addr_n;
	logic [XFER_W-1:0] remain_n;
	logic [XFER_W-1:0] pos_n;
	logic [SRC_W-1:0]  desc_n;

	// Result of this event
	logic [FLAGS_W-1:0] flags;
	logic               addr_wr;
	logic [FADDR_W-1:0] addr_val;
	logic [SRC_W-1:0]   src_o;
	logic [OFFSET_W-1:0] off_o;
	logic [TXLEN_W-1:0] len_o;

	// Packet builder
	logic              do_send;
	logic              load;
	logic [XFER_W-1:0] snd_rem;
	logic [XFER_W-1:0] snd_pos;
	logic [SRC_W-1:0]  snd_desc;
	logic [XFER_W-1:0] pkt_len;
	logic [XFER_W-1:0] rem_after;

	// Result register
	logic                res_valid_q;
	logic [FLAGS_W-1:0]  flags_q;
	logic                addr_wr_q;
	logic [FADDR_W-1:0]  addr_val_q;
	logic [SRC_W-1:0]    src_q;
	logic [OFFSET_W-1:0] off_q;
	logic [TXLEN_W-1:0]  len_q;
	phase_t              phase_res_q;
	logic [CFGVAL_W-1:0] cfg_res_q;

	assign pop = cmd_valid && (!res_valid_q || res.ready);

	// Event decision
	always_comb begin
		phase_n     = phase_q;
		pend_addr_n = pend_addr_q;
		sel_cfg_n   = sel_cfg_q;
		func_addr_n = func_addr_q;
		remain_n    = remain_q;
		pos_n       = pos_q;
		desc_n      = desc_q;
		flags       = '0;
		addr_wr     = 1'b0;
		addr_val    = '0;
		src_o       = SRC_NONE;
		off_o       = '0;
		len_o       = '0;
		do_send     = 1'b0;
		load        = 1'b0;

		if (cmd.bus_reset) begin
			phase_n     = PH_RESET;
			pend_addr_n = '0;
			sel_cfg_n   = '0;
			func_addr_n = '0;
			remain_n    = '0;
			pos_n       = '0;
			desc_n      = SRC_NONE;
			addr_wr     = 1'b1;
		end else begin
			if (phase_n == PH_RESET) begin
				phase_n = PH_IDLE;
			end
			if (cmd.setup_end) begin
				flags[FLG_CLR_SETEND] = 1'b1;
				if (phase_n != PH_ZERO) begin
					phase_n = PH_IDLE;
				end
			end
			priority if (cmd.stalled) begin
				flags[FLG_CLR_STALLED] = 1'b1;
			end else if (phase_n == PH_TX) begin
				do_send = 1'b1;
			end else if (phase_n == PH_ZERO || phase_n == PH_STATUS) begin
				// Address takes effect after the status stage
				if (pend_addr_q != 8'd0 && func_addr_q == '0) begin
					func_addr_n = pend_addr_q[FADDR_W-1:0];
					addr_wr     = 1'b1;
					addr_val    = pend_addr_q[FADDR_W-1:0];
				end
				phase_n = PH_IDLE;
			end else if (!cmd.rx_ready) begin
				phase_n = phase_n;
			end else if (cmd.oversize) begin
				flags[FLG_STALL] = 1'b1;
				phase_n = PH_IDLE;
			end else if (phase_n == PH_IDLE) begin
				if (!cmd.setup_ok) begin
					flags[FLG_FLUSH] = 1'b1;
				end else begin
					unique case (cmd.cls)
						CMD_ZERO_OK: begin
							flags[FLG_RX_ACK]   = 1'b1;
							flags[FLG_DATA_END] = 1'b1;
							phase_n = PH_ZERO;
						end
						CMD_SET_ADDR: begin
							pend_addr_n = cmd.wval_lo;
							flags[FLG_RX_ACK]   = 1'b1;
							flags[FLG_DATA_END] = 1'b1;
							phase_n = PH_ZERO;
						end
						CMD_SET_CFG: begin
							sel_cfg_n = cmd.wval_lo;
							flags[FLG_RX_ACK]   = 1'b1;
							flags[FLG_DATA_END] = 1'b1;
							phase_n = PH_ZERO;
						end
						CMD_READ: begin
							flags[FLG_RX_ACK] = 1'b1;
							load    = 1'b1;
							do_send = 1'b1;
						end
						CMD_WRITE: begin
							flags[FLG_RX_ACK] = 1'b1;
							phase_n = PH_RX;
						end
						default: begin
							flags[FLG_STALL] = 1'b1;
						end
					endcase
				end
			end else if (phase_n == PH_RX) begin
				flags[FLG_RX_ACK]   = 1'b1;
				flags[FLG_DATA_END] = 1'b1;
				phase_n = PH_IDLE;
			end
		end

		// Next IN packet, from a new transfer or the one in progress
		snd_rem   = load ? cmd.total : remain_q;
		snd_pos   = load ? '0 : pos_q;
		snd_desc  = load ? cmd.desc : desc_q;
		pkt_len   = (snd_rem < XFER_W'(MAX_PACKET)) ? snd_rem : XFER_W'(MAX_PACKET);
		rem_after = snd_rem - pkt_len;
		if (do_send) begin
			src_o    = snd_desc;
			off_o    = snd_pos;
			len_o    = pkt_len[TXLEN_W-1:0];
			remain_n = rem_after;
			pos_n    = snd_pos + pkt_len;
			desc_n   = snd_desc;
			flags[FLG_TX_READY] = 1'b1;
			if (rem_after == '0) begin
				flags[FLG_DATA_END] = 1'b1;
				phase_n = PH_STATUS;
			end else begin
				phase_n = PH_TX;
			end
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_RESET;
			pend_addr_q <= '0;
			sel_cfg_q   <= '0;
			func_addr_q <= '0;
			remain_q    <= '0;
			pos_q       <= '0;
			desc_q      <= SRC_NONE;
		end else if (pop) begin
			phase_q     <= phase_n;
			pend_addr_q <= pend_addr_n;
			sel_cfg_q   <= sel_cfg_n;
			func_addr_q <= func_addr_n;
			remain_q    <= remain_n;
			pos_q       <= pos_n;
			desc_q      <= desc_n;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			flags_q     <= flags;
			addr_wr_q   <= addr_wr;
			addr_val_q  <= addr_val;
			src_q       <= src_o;
			off_q       <= off_o;
			len_q       <= len_o;
			phase_res_q <= phase_n;
			cfg_res_q   <= sel_cfg_n;
		end
	end

	assign res.valid               = res_valid_q;
	assign res.action_flags        = flags_q;
	assign res.addr_write          = addr_wr_q;
	assign res.func_address        = addr_val_q;
	assign res.tx_source           = src_q;
	assign res.tx_offset           = off_q;
	assign res.tx_length           = len_q;
	assign res.ep_phase            = phase_res_q;
	assign res.configuration_value = cfg_res_q;

	`ASSERT_IMPLY(a_no_src_no_packet, res_valid_q && src_q == SRC_NONE,
		off_q == '0 && len_q == '0, "packet fields set without a descriptor source")
	`ASSERT_IMPLY(a_src_in_data_phase, res_valid_q && src_q != SRC_NONE,
		phase_res_q == PH_TX || phase_res_q == PH_STATUS, "IN packet outside data stage")
	`ASSERT_IMPLY(a_reset_writes_zero, res_valid_q && phase_res_q == PH_RESET,
		addr_wr_q && addr_val_q == '0 && flags_q == '0, "bus reset result malformed")
	`ASSERT_NEXT(a_pop_gives_result, pop, res_valid_q, "popped event left no result")

endmodule

`default_nettype wire

FILE: hw/rtl/usb_control_endpoint_fsm.sv
// Top level of the endpoint-zero control block: config registers, front, queue, back.
// An event is loaded into the front stage register when taken, then into a queue
// entry, then the result register. While res.ready holds, one event per cycle is
// sustained and the back state machine decides one event per cycle.
// Reset (arst_n low) clears phase to reset, address, configuration and
// transfer state, empties the queue, and loads the descriptor lengths 18 and 67.
`default_nettype none

module usb_control_endpoint_fsm
	import ucep_pkg::*;
#(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	ep_event_if.sink    ev,
	ep_result_if.source res,
	cfg_wr_if.sink      cfg
);

	logic [DEVLEN_W-1:0] dev_len_q;
	logic [XFER_W-1:0]   cfg_total_q;
	logic                front_valid_s1;
	cmd_t                front_cmd_s1;
	logic                q_ready;
	logic                q_pop;
	cmd_t                q_cmd;
	logic                q_valid;

	// Configuration registers, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_len_q   <= DEV_LEN_RESET;
			cfg_total_q <= CFG_TOTAL_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_IDX_DEV_LEN) begin
				dev_len_q <= cfg.data[DEVLEN_W-1:0];
			end else if (cfg.index == CFG_IDX_CFG_TOTAL) begin
				cfg_total_q <= cfg.data[XFER_W-1:0];
			end
		end
	end

	ucep_front #(
		.MAX_PACKET(MAX_PACKET)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev         (ev),
		.dev_len    (dev_len_q),
		.cfg_total  (cfg_total_q),
		.valid_s1   (front_valid_s1),
		.cmd_s1     (front_cmd_s1),
		.push_ready (q_ready)
	);

	ucep_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_valid_s1 && q_ready),
		.push_cmd   (front_cmd_s1),
		.push_ready (q_ready),
		.pop        (q_pop),
		.pop_cmd    (q_cmd),
		.pop_valid  (q_valid)
	);

	ucep_back #(
		.MAX_PACKET(MAX_PACKET)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.cmd_valid (q_valid),
		.pop       (q_pop),
		.res       (res)
	);

endmodule

`default_nettype wire
